### src/ialu_pkg.sv
`timescale 1ns / 1ps
package ialu_pkg;

    localparam int XLEN = 64;
    localparam int HLEN = 32;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int DIV_STEPS = 64;
    localparam int STEP_W = 7;

    typedef enum logic [4:0] {
        OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_UDIV = 5'd3,
        OP_SDIV = 5'd4,  OP_UREM = 5'd5,  OP_SREM = 5'd6,  OP_SHL  = 5'd7,
        OP_LSHR = 5'd8,  OP_ASHR = 5'd9,  OP_AND  = 5'd10, OP_OR   = 5'd11,
        OP_XOR  = 5'd12, OP_EQ   = 5'd13, OP_NE   = 5'd14, OP_UGT  = 5'd15,
        OP_UGE  = 5'd16, OP_ULT  = 5'd17, OP_ULE  = 5'd18, OP_SGT  = 5'd19,
        OP_SGE  = 5'd20, OP_SLT  = 5'd21, OP_SLE  = 5'd22
    } op_t;

    localparam logic [4:0] OP_LAST = 5'd22;

    // classified transaction passed from front to back
    typedef struct packed {
        logic [4:0]      mode;
        logic            wide;
        logic            bad;
        logic            is_div;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
    } item_t;

endpackage

### src/ialu_front.sv
`timescale 1ns / 1ps
module ialu_front import ialu_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [4:0]      s_mode,
    input  logic            s_wide,
    input  logic [XLEN-1:0] s_operand_a,
    input  logic [XLEN-1:0] s_operand_b,
    output logic            q_valid,
    input  logic            q_ready,
    output item_t           q_item
);

    item_t mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    item_t in_item;
    logic push, pop;

    // mask operands to width and classify
    always_comb begin
        in_item.mode   = s_mode;
        in_item.wide   = s_wide;
        in_item.bad    = (s_mode > OP_LAST);
        in_item.is_div = (s_mode == OP_UDIV) || (s_mode == OP_SDIV) ||
                         (s_mode == OP_UREM) || (s_mode == OP_SREM);
        in_item.a = s_wide ? s_operand_a : {{HLEN{1'b0}}, s_operand_a[HLEN-1:0]};
        in_item.b = s_wide ? s_operand_b : {{HLEN{1'b0}}, s_operand_b[HLEN-1:0]};
    end

    assign s_ready = (cnt_reg != (QPTR_W+1)'(QDEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_valid && q_ready;
    assign q_item  = mem_reg[rd_reg];

    // queue pointers
    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

endmodule

### src/ialu_div.sv
`timescale 1ns / 1ps
module ialu_div import ialu_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  item_t           item,
    output logic            busy,
    output logic            done,
    input  logic            take,
    output logic [XLEN-1:0] quot,
    output logic [XLEN-1:0] rem
);

    logic [XLEN-1:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic run_reg, run_next, done_reg, done_next;
    logic [XLEN:0] trial;

    assign busy = run_reg || done_reg;
    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;
    assign trial = {r_reg, q_reg[XLEN-1]} - {1'b0, d_reg};

    // restoring divide, one quotient bit per cycle
    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        step_next = step_reg; run_next = run_reg; done_next = done_reg;
        if (start) begin
            q_next = item.a; r_next = '0; d_next = item.b;
            step_next = '0; run_next = 1'b1; done_next = 1'b0;
        end else if (run_reg) begin
            if (!trial[XLEN]) begin
                r_next = trial[XLEN-1:0];
                q_next = {q_reg[XLEN-2:0], 1'b1};
            end else begin
                r_next = {r_reg[XLEN-2:0], q_reg[XLEN-1]};
                q_next = {q_reg[XLEN-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                run_next = 1'b0; done_next = 1'b1;
            end
        end else if (done_reg && take) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0; done_reg <= 1'b0; step_reg <= '0;
        end else begin
            run_reg <= run_next; done_reg <= done_next; step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
    end

endmodule

### src/ialu_back.sv
`timescale 1ns / 1ps
module ialu_back import ialu_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  item_t           q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [XLEN-1:0] m_result,
    output logic            m_bad_mode
);

    // stage 1: item, ALU result and multiplier partial products registered
    logic            s1_v_reg;
    item_t           s1_reg;
    logic [HLEN-1:0] pll_reg, plh_reg, phl_reg, phh_lo_unused;
    logic [XLEN-1:0] ll_reg;
    logic [XLEN-1:0] s1_alu_reg;
    logic            s1_div_reg;
    // division unit holding slot
    item_t           dv_reg;
    logic            dv_busy, dv_done, dv_start, dv_take;
    logic [XLEN-1:0] dv_q, dv_r;
    // output register
    logic            o_v_reg;
    logic [XLEN-1:0] o_res_reg;
    logic            o_bad_reg;

    logic [XLEN-1:0] mask, sbit, smax, a, b, ma, mb, alu_r, sa, sb;
    logic [5:0]      sh;
    logic            an, bn;
    logic            adv, out_free;

    assign phh_lo_unused = '0;
    assign out_free = !o_v_reg || m_ready;
    // a divide waits for the unit; other items pass through stage 1 when the output is free
    assign adv     = !s1_v_reg || (out_free && !(s1_div_reg && !dv_done));
    assign q_ready = adv && !(q_item.is_div && !q_item.bad && dv_busy && !dv_take);

    always_comb begin
        mask = q_item.wide ? {XLEN{1'b1}} : {{HLEN{1'b0}}, {HLEN{1'b1}}};
        sbit = q_item.wide ? {1'b1, {(XLEN-1){1'b0}}} : (XLEN)'(64'h8000_0000);
        a = q_item.a; b = q_item.b;
        sh = q_item.wide ? b[5:0] : {1'b0, b[4:0]};
        an = |(a & sbit); bn = |(b & sbit);
        ma = an ? ((~a + 1'b1) & mask) : a;
        mb = bn ? ((~b + 1'b1) & mask) : b;
        sa = a ^ sbit; sb = b ^ sbit;
        alu_r = '0;
        case (q_item.mode)
            OP_ADD:  alu_r = a + b;
            OP_SUB:  alu_r = a - b;
            OP_SHL:  alu_r = a << sh;
            OP_LSHR: alu_r = a >> sh;
            OP_ASHR: alu_r = (a >> sh) | ((an && sh != 6'd0) ? (mask & ~(mask >> sh)) : '0);
            OP_AND:  alu_r = a & b;
            OP_OR:   alu_r = a | b;
            OP_XOR:  alu_r = a ^ b;
            OP_EQ:   alu_r = XLEN'(a == b);
            OP_NE:   alu_r = XLEN'(a != b);
            OP_UGT:  alu_r = XLEN'(a > b);
            OP_UGE:  alu_r = XLEN'(a >= b);
            OP_ULT:  alu_r = XLEN'(a < b);
            OP_ULE:  alu_r = XLEN'(a <= b);
            OP_SGT:  alu_r = XLEN'(sa > sb);
            OP_SGE:  alu_r = XLEN'(sa >= sb);
            OP_SLT:  alu_r = XLEN'(sa < sb);
            OP_SLE:  alu_r = XLEN'(sa <= sb);
            default: alu_r = '0;
        endcase
    end

    // divider runs on magnitudes for signed modes
    item_t dv_in;
    always_comb begin
        dv_in = q_item;
        if (q_item.mode == OP_SDIV || q_item.mode == OP_SREM) begin
            dv_in.a = ma; dv_in.b = mb;
        end
    end
    assign dv_start = q_valid && q_ready && q_item.is_div && !q_item.bad;
    assign dv_take  = s1_v_reg && s1_div_reg && dv_done && out_free;

    ialu_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .item(dv_in),
        .busy(dv_busy), .done(dv_done), .take(dv_take), .quot(dv_q), .rem(dv_r)
    );

    // stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg <= q_valid && q_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && q_valid && q_ready) begin
            s1_reg     <= q_item;
            s1_div_reg <= q_item.is_div && !q_item.bad;
            s1_alu_reg <= alu_r;
            ll_reg     <= a[HLEN-1:0] * b[HLEN-1:0];
            plh_reg    <= a[HLEN-1:0] * b[XLEN-1:HLEN];
            phl_reg    <= a[XLEN-1:HLEN] * b[HLEN-1:0];
            pll_reg    <= '0;
        end
        if (dv_start) begin
            dv_reg <= q_item;
        end
    end

    // finish result at stage 1 output
    logic [XLEN-1:0] fin, m1, dr, smask, ssbit;
    logic            dan, dbn, bz;
    always_comb begin
        smask = s1_reg.wide ? {XLEN{1'b1}} : {{HLEN{1'b0}}, {HLEN{1'b1}}};
        ssbit = s1_reg.wide ? {1'b1, {(XLEN-1){1'b0}}} : (XLEN)'(64'h8000_0000);
        smax  = s1_reg.wide ? {1'b0, {(XLEN-1){1'b1}}} : (XLEN)'(64'h7FFF_FFFF);
        dan = |(dv_reg.a & ssbit); dbn = |(dv_reg.b & ssbit);
        bz  = (dv_reg.b == '0);
        m1 = ll_reg + {plh_reg + phl_reg + pll_reg + phh_lo_unused, {HLEN{1'b0}}};
        dr = '0;
        case (s1_reg.mode)
            OP_UDIV: dr = dv_q;
            OP_UREM: dr = dv_r;
            OP_SDIV: dr = (dan != dbn) ? (~dv_q + 1'b1) : dv_q;
            OP_SREM: dr = dan ? (~dv_r + 1'b1) : dv_r;
            default: dr = '0;
        endcase
        if (bz) dr = smax;
        fin = s1_reg.bad ? '0 : (s1_div_reg ? dr : (s1_reg.mode == OP_MUL ? m1 : s1_alu_reg));
        fin = fin & smask;
    end

    assign m_valid    = o_v_reg;
    assign m_result   = o_res_reg;
    assign m_bad_mode = o_bad_reg;

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_v_reg <= 1'b0;
        end else if (out_free) begin
            o_v_reg <= s1_v_reg && !(s1_div_reg && !dv_done);
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            o_res_reg <= fin;
            o_bad_reg <= s1_reg.bad;
        end
    end

endmodule

### src/integer_alu_with_compare_top.sv
`timescale 1ns / 1ps
// channel | ports                                   | direction
// s_      | s_valid s_ready s_mode s_wide s_operand_a/b | in
// m_      | m_valid m_ready m_result m_bad_mode       | out
// one transaction per cycle for all modes but divide and remainder, while m_ready is high
// and no divide waits in stage 1; a result passes the queue, stage 1 with 32x32 partial
// products and the output register. divide and remainder use a radix-2 unit of 64 steps,
// one at a time; later items wait behind it in order.
// a low m_ready stalls the pipeline; the 4-entry queue keeps accepting until full.
// reset is synchronous, active low, and empties queue and pipeline.
module integer_alu_with_compare_top import ialu_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [4:0]      s_mode,
    input  logic            s_wide,
    input  logic [XLEN-1:0] s_operand_a,
    input  logic [XLEN-1:0] s_operand_b,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [XLEN-1:0] m_result,
    output logic            m_bad_mode
);

    logic  q_valid, q_ready;
    item_t q_item;

    ialu_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(s_mode), .s_wide(s_wide), .s_operand_a(s_operand_a),
        .s_operand_b(s_operand_b), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    ialu_back u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .m_valid(m_valid), .m_ready(m_ready),
        .m_result(m_result), .m_bad_mode(m_bad_mode)
    );

endmodule
